>>> rtl/lrsa_pkg.sv
// lrsa_pkg: shared types for the loop ratio sync adjust unit
// no dependencies; imported by every module of the block
package lrsa_pkg;

    // pipeline control handed to each stage cell
    typedef struct packed {
        logic valid;
        logic adv;
    } pipe_ctl_t;

endpackage

>>> rtl/lrsa_div_cell.sv
// lrsa_div_cell: one restoring-division step, resolves one quotient bit
// depends on lrsa_pkg
module lrsa_div_cell #(
    parameter int NUM_W  = 26,
    parameter int DEN_W  = 25,
    parameter int Q_W    = 24,
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lrsa_pkg::pipe_ctl_t ctl,
    input  logic [NUM_W-1:0]  rem_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [Q_W-1:0]    quo_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [NUM_W-1:0]  rem_out,
    output logic [DEN_W-1:0]  den_out,
    output logic [Q_W-1:0]    quo_out,
    output logic [SIDE_W-1:0] side_out
);
    import lrsa_pkg::*;

    localparam int XW = (NUM_W > DEN_W + BIT) ? NUM_W : DEN_W + BIT;

    logic [XW-1:0]     rem_x;
    logic [XW-1:0]     den_x;
    logic [XW-1:0]     diff;
    logic              ge;
    logic [NUM_W-1:0]  rem_next;
    logic [Q_W-1:0]    quo_next;
    logic              valid_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [SIDE_W-1:0] side_reg;

    // trial subtract of the shifted divisor
    always_comb begin
        rem_x         = XW'(rem_in);
        den_x         = XW'(den_in) << BIT;
        ge            = rem_x >= den_x;
        diff          = rem_x - den_x;
        rem_next      = ge ? diff[NUM_W-1:0] : rem_in;
        quo_next      = quo_in;
        quo_next[BIT] = ge;
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.adv) begin
            valid_reg <= ctl.valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign quo_out   = quo_reg;
    assign side_out  = side_reg;

endmodule

>>> rtl/lrsa_div.sv
// lrsa_div: pipelined divider built as a chain of one-bit cells
// depends on lrsa_pkg and lrsa_div_cell
module lrsa_div #(
    parameter int NUM_W  = 26,
    parameter int DEN_W  = 25,
    parameter int Q_W    = 24,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              valid_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [Q_W-1:0]    quo_out,
    output logic [SIDE_W-1:0] side_out
);
    import lrsa_pkg::*;

    logic              vld  [0:Q_W];
    logic [NUM_W-1:0]  rem  [0:Q_W];
    logic [DEN_W-1:0]  den  [0:Q_W];
    logic [Q_W-1:0]    quo  [0:Q_W];
    logic [SIDE_W-1:0] side [0:Q_W];

    assign vld[0]  = valid_in;
    assign rem[0]  = num_in;
    assign den[0]  = den_in;
    assign quo[0]  = '0;
    assign side[0] = side_in;

    // most significant quotient bit first
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        pipe_ctl_t ctl;
        assign ctl.valid = vld[k];
        assign ctl.adv   = adv;
        lrsa_div_cell #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .Q_W   (Q_W),
            .BIT   (Q_W - 1 - k),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .rem_in   (rem[k]),
            .den_in   (den[k]),
            .quo_in   (quo[k]),
            .side_in  (side[k]),
            .valid_out(vld[k+1]),
            .rem_out  (rem[k+1]),
            .den_out  (den[k+1]),
            .quo_out  (quo[k+1]),
            .side_out (side[k+1])
        );
    end

    assign valid_out = vld[Q_W];
    assign quo_out   = quo[Q_W];
    assign side_out  = side[Q_W];

endmodule

>>> rtl/lrsa_pick_cell.sv
// lrsa_pick_cell: one candidate of the search, compares it with the running best
// depends on lrsa_pkg; candidate layout {ok, neg, mag, n, m}
module lrsa_pick_cell #(
    parameter int CW  = 24,
    parameter int NC  = 6,
    parameter int IDX = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lrsa_pkg::pipe_ctl_t      ctl,
    input  logic [3*CW+1:0]          best_in,
    input  logic [NC*(3*CW+2)-1:0]   cands_in,
    output logic                     valid_out,
    output logic [3*CW+1:0]          best_out,
    output logic [NC*(3*CW+2)-1:0]   cands_out
);
    import lrsa_pkg::*;

    localparam int CAND_W = 3 * CW + 2;

    logic [CAND_W-1:0]    cand_in;
    logic                 valid_a_reg;
    logic [CAND_W-1:0]    best_a_reg;
    logic [CAND_W-1:0]    cand_a_reg;
    logic [NC*CAND_W-1:0] cands_a_reg;
    logic [2*CW-1:0]      p_cand_reg;
    logic [2*CW-1:0]      p_best_reg;
    logic                 take;
    logic                 valid_b_reg;
    logic [CAND_W-1:0]    best_b_reg;
    logic [NC*CAND_W-1:0] cands_b_reg;

    assign cand_in = cands_in[IDX*CAND_W +: CAND_W];

    // cross products of the two error fractions
    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            p_cand_reg  <= (2*CW)'(cand_in[3*CW-1:2*CW]) * (2*CW)'(best_in[CW-1:0]);
            p_best_reg  <= (2*CW)'(best_in[3*CW-1:2*CW]) * (2*CW)'(cand_in[CW-1:0]);
            best_a_reg  <= best_in;
            cand_a_reg  <= cand_in;
            cands_a_reg <= cands_in;
        end
    end

    // an accepted candidate replaces the best when the best is not accepted or its error is strictly smaller
    assign take = cand_a_reg[CAND_W-1] && (!best_a_reg[CAND_W-1] || p_cand_reg < p_best_reg);

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            best_b_reg  <= take ? cand_a_reg : best_a_reg;
            cands_b_reg <= cands_a_reg;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (ctl.adv) begin
            valid_a_reg <= ctl.valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign valid_out = valid_b_reg;
    assign best_out  = best_b_reg;
    assign cands_out = cands_b_reg;

endmodule

>>> rtl/loop_ratio_sync_adjust_unit.sv
// loop_ratio_sync_adjust_unit: top level of the loop ratio search
// depends on lrsa_pkg, lrsa_div, lrsa_pick_cell
//
// usage
//   s_ channel takes one transaction per item: base length, new length and
//   largest permitted shortening, all in ticks. m_ channel returns one
//   transaction per item: chosen ratio n:m, the rounded adjustment in ticks
//   and a found flag in m_tuser.
// throughput
//   one item per cycle while the output is not stalled; the pipeline is built
//   from two bit-per-stage divider chains and the row of compare cells, two
//   stages per candidate ratio.
// reset
//   aresetn low clears every stage valid and the output valid; no item
//   is in flight afterwards and no start-up pass is needed.
// back-pressure
//   the whole pipeline advances when the output register is empty or taken;
//   while m_tready holds a waiting result low, s_tready is low too.
module loop_ratio_sync_adjust_unit #(
    parameter int COUNT_BITS   = 24,
    parameter int SEARCH_LIMIT = 7
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // base_ticks, length_ticks, max_shorten
    input  logic [((3*COUNT_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // adjust_ticks, ratio_n, ratio_m
    output logic [((3*COUNT_BITS+1+7)/8)*8-1:0] m_tdata,
    // found
    output logic [0:0] m_tuser
);
    import lrsa_pkg::*;

    localparam int CW     = COUNT_BITS;
    localparam int NC     = SEARCH_LIMIT - 1;
    localparam int KW     = $clog2(SEARCH_LIMIT);
    localparam int TW     = CW + KW + 3;
    localparam int CAND_W = 3 * CW + 2;
    localparam int SIDE1  = 2 + 3 * CW + NC * (KW + 1);
    localparam int OUT_W  = ((3 * CW + 1 + 7) / 8) * 8;

    logic adv;

    // input register
    logic          v0_reg;
    logic [CW-1:0] b_reg, l_reg, ms_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_reg  <= s_tdata[CW-1:0];
            l_reg  <= s_tdata[2*CW-1:CW];
            ms_reg <= s_tdata[3*CW-1:2*CW];
        end
    end

    // orientation: s is the shorter side, the longer side gets scaled
    logic          swap, zero;
    logic [CW-1:0] s_len, g_len;
    assign swap  = b_reg < l_reg;
    assign zero  = (b_reg == '0) || (l_reg == '0);
    assign s_len = swap ? b_reg : l_reg;
    assign g_len = swap ? l_reg : b_reg;

    // small candidates: count thresholds instead of dividing
    logic [NC*KW-1:0] kvec;
    logic [NC-1:0]    kok;
    assign kvec[KW-1:0] = '0;
    assign kok[0]       = 1'b1;

    for (genvar c = 1; c < NC; c++) begin : g_small
        logic [TW-1:0] xval;
        logic [KW:0]   cnt;
        assign xval = ((TW'(g_len) * TW'(c + 1)) << 1) + TW'(s_len);
        always_comb begin
            cnt = '0;
            for (int j = 1; j <= SEARCH_LIMIT; j++) begin
                if (xval >= ((TW'(s_len) * TW'(j)) << 1)) begin
                    cnt = cnt + 1'b1;
                end
            end
        end
        assign kvec[c*KW +: KW] = cnt[KW-1:0];
        assign kok[c]           = cnt < (KW+1)'(SEARCH_LIMIT);
    end

    // full division for the first candidate
    logic             v1;
    logic [CW-1:0]    q1;
    logic [SIDE1-1:0] side1;

    lrsa_div #(
        .NUM_W (CW + 2),
        .DEN_W (CW + 1),
        .Q_W   (CW),
        .SIDE_W(SIDE1)
    ) u_div_ratio (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .valid_in (v0_reg),
        .num_in   ((CW+2)'({g_len, 1'b0}) + (CW+2)'(s_len)),
        .den_in   ({s_len, 1'b0}),
        .side_in  ({zero, swap, ms_reg, s_len, g_len, kvec, kok}),
        .valid_out(v1),
        .quo_out  (q1),
        .side_out (side1)
    );

    logic             d_zero, d_swap;
    logic [CW-1:0]    d_ms, d_s, d_g;
    logic [NC*KW-1:0] d_kvec;
    logic [NC-1:0]    d_kok;
    assign {d_zero, d_swap, d_ms, d_s, d_g, d_kvec, d_kok} = side1;

    // products of each candidate
    logic          ve1_reg, ve2_reg;
    logic          e1_zero_reg, e1_swap_reg;
    logic [CW-1:0] e1_ms_reg;
    logic [NC*CAND_W-1:0] cands_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve1_reg <= 1'b0;
            ve2_reg <= 1'b0;
        end else if (adv) begin
            ve1_reg <= v1;
            ve2_reg <= ve1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_zero_reg <= d_zero;
            e1_swap_reg <= d_swap;
            e1_ms_reg   <= d_ms;
        end
    end

    for (genvar c = 0; c < NC; c++) begin : g_lane
        logic [CW-1:0]   k_c, n_c, m_c;
        logic [2*CW-1:0] ks_reg, ig_reg, msm_reg;
        logic [CW-1:0]   n_reg, m_reg;
        logic            lok_reg;
        logic [2*CW-1:0] nb, ml, mag;
        logic            neg, ok;

        assign k_c = (c == 0) ? q1 : CW'(d_kvec[c*KW +: KW]);
        assign n_c = d_swap ? k_c : CW'(c + 1);
        assign m_c = d_swap ? CW'(c + 1) : k_c;

        always_ff @(posedge aclk) begin
            if (adv) begin
                ks_reg  <= (2*CW)'(k_c) * (2*CW)'(d_s);
                ig_reg  <= (2*CW)'(d_g) * (2*CW)'(c + 1);
                msm_reg <= (2*CW)'(d_ms) * (2*CW)'(m_c);
                n_reg   <= n_c;
                m_reg   <= m_c;
                lok_reg <= d_kok[c];
            end
        end

        // signed error and acceptance against the shortening limit
        always_comb begin
            nb  = e1_swap_reg ? ks_reg : ig_reg;
            ml  = e1_swap_reg ? ig_reg : ks_reg;
            neg = nb < ml;
            mag = neg ? (ml - nb) : (nb - ml);
            ok  = lok_reg && !e1_zero_reg &&
                  (neg ? (mag < msm_reg) : ((mag != '0) || (e1_ms_reg != '0)));
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cands_reg[c*CAND_W +: CAND_W] <= {ok, neg, mag[CW-1:0], n_reg, m_reg};
            end
        end
    end

    // row of compare cells, first candidate first
    logic                 pv    [0:NC];
    logic [CAND_W-1:0]    pbest [0:NC];
    logic [NC*CAND_W-1:0] pcand [0:NC];

    assign pv[0]    = ve2_reg;
    assign pbest[0] = '0;
    assign pcand[0] = cands_reg;

    for (genvar c = 0; c < NC; c++) begin : g_pick
        pipe_ctl_t ctl;
        assign ctl.valid = pv[c];
        assign ctl.adv   = adv;
        lrsa_pick_cell #(
            .CW (CW),
            .NC (NC),
            .IDX(c)
        ) u_pick (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .best_in  (pbest[c]),
            .cands_in (pcand[c]),
            .valid_out(pv[c+1]),
            .best_out (pbest[c+1]),
            .cands_out(pcand[c+1])
        );
    end

    // rounding divide of the best error
    logic [CW-1:0]     best_mag, best_m;
    logic              v2;
    logic [CW-1:0]     q2;
    logic [CAND_W-1:0] best_fin;

    assign best_mag = pbest[NC][3*CW-1:2*CW];
    assign best_m   = pbest[NC][CW-1:0];

    lrsa_div #(
        .NUM_W (CW + 2),
        .DEN_W (CW + 1),
        .Q_W   (CW),
        .SIDE_W(CAND_W)
    ) u_div_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .valid_in (pv[NC]),
        .num_in   ((CW+2)'({best_mag, 1'b0}) + (CW+2)'(best_m)),
        .den_in   ({best_m, 1'b0}),
        .side_in  (pbest[NC]),
        .valid_out(v2),
        .quo_out  (q2),
        .side_out (best_fin)
    );

    // output register
    logic          out_valid_reg;
    logic          found_reg;
    logic [CW:0]   adj_reg;
    logic [CW-1:0] n_out_reg, m_out_reg;
    logic          f_ok, f_neg;

    assign f_ok  = best_fin[CAND_W-1];
    assign f_neg = best_fin[CAND_W-2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            found_reg <= f_ok;
            adj_reg   <= !f_ok ? '0 : (f_neg ? ((CW+1)'(0) - (CW+1)'(q2)) : (CW+1)'(q2));
            n_out_reg <= f_ok ? best_fin[2*CW-1:CW] : '0;
            m_out_reg <= f_ok ? best_fin[CW-1:0] : '0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = found_reg;
    assign m_tdata    = OUT_W'({m_out_reg, n_out_reg, adj_reg});

    // a missing ratio reports all zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> adj_reg == '0 && n_out_reg == '0 && m_out_reg == '0)
        else $error("not-found result carries nonzero fields");

    // a found ratio has both sides nonzero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> n_out_reg != '0 && m_out_reg != '0)
        else $error("found ratio with a zero side");

    // a stalled result holds the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is stalled");

endmodule
